// ===== hdl/utv_pkg.sv =====
// Shared types and constants for the UTF-8 to varint transcoder.
// No dependencies; every other file refers to it by scoped names.
package utv_pkg;

	localparam int BYTE_W  = 8;
	localparam int CP_W    = 21;
	localparam int GROUP_W = 7;
	localparam int REST_W  = CP_W - GROUP_W;

	localparam logic [1:0] BL_IDLE = 2'd0;
	localparam logic [1:0] BL_ONE  = 2'd1;
	localparam logic [1:0] BL_TWO  = 2'd2;
	localparam logic [1:0] BL_THREE = 2'd3;

	localparam logic [1:0] CONT_TAG  = 2'b10;
	localparam logic [4:0] BAD_HIGH  = 5'b11111;

	// controller -> datapath
	typedef struct packed {
		logic take_in;
		logic emit_step;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic res_valid;
		logic res_more;
		logic emit_last;
	} dp_sts_t;

endpackage

// ===== hdl/utv_in_if.sv =====
// Input word channel: valid/ready handshake with one raw UTF-8 byte.
// Depends on utv_pkg.
interface utv_in_if;
	logic                         valid;
	logic                         ready;
	logic [utv_pkg::BYTE_W-1:0]   byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

// ===== hdl/utv_out_if.sv =====
// Output word channel: valid/ready handshake with one varint byte and flags.
// Depends on utv_pkg.
interface utv_out_if;
	logic                         valid;
	logic                         ready;
	logic [utv_pkg::BYTE_W-1:0]   byte_out;
	logic                         last_byte;
	logic                         bad_lead;

	modport source (output valid, output byte_out, output last_byte, output bad_lead,
		input ready);
	modport sink (input valid, input byte_out, input last_byte, input bad_lead,
		output ready);
endinterface

// ===== hdl/utv_ctrl.sv =====
// Handshake controller for the transcoder: input/output flow and varint emission.
// Depends on utv_pkg.
module utv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	input  utv_pkg::dp_sts_t  sts,
	output utv_pkg::ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q, state_n;
	logic   ovalid_q, ovalid_n;
	logic   out_free;

	assign out_free  = !ovalid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign out_valid = ovalid_q;

	assign cmd.take_in   = in_valid && in_ready;
	assign cmd.emit_step = (state_q == ST_EMIT) && out_free;

	always_comb begin
		state_n  = state_q;
		ovalid_n = ovalid_q;
		if (ovalid_q && out_ready) begin
			ovalid_n = 1'b0;
		end
		if (cmd.take_in && sts.res_valid) begin
			ovalid_n = 1'b1;
		end
		if (cmd.emit_step) begin
			ovalid_n = 1'b1;
		end
		case (state_q)
			ST_IDLE: begin
				if (cmd.take_in && sts.res_more) begin
					state_n = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (cmd.emit_step && sts.emit_last) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			ovalid_q <= ovalid_n;
		end
	end

endmodule

// ===== hdl/utv_dp.sv =====
// Datapath: UTF-8 decode state, code point gathering and varint byte register.
// Depends on utv_pkg.
module utv_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [utv_pkg::BYTE_W-1:0] byte_in,
	input  utv_pkg::ctl_cmd_t          cmd,
	output utv_pkg::dp_sts_t           sts,
	output logic [utv_pkg::BYTE_W-1:0] byte_out,
	output logic                       last_byte,
	output logic                       bad_lead
);

	logic [1:0]                    bl_q, bl_n;
	logic [utv_pkg::CP_W-1:0]      acc_q, acc_n, acc_cat, cp;
	logic [utv_pkg::REST_W-1:0]    rest_q;
	logic [utv_pkg::BYTE_W-1:0]    obyte_q;
	logic                          olast_q, obad_q;
	logic                          res_code, res_bad, first_more;

	assign acc_cat = {acc_q[utv_pkg::CP_W-7:0], byte_in[5:0]};

	always_comb begin
		bl_n     = bl_q;
		acc_n    = acc_q;
		res_code = 1'b0;
		res_bad  = 1'b0;
		cp       = '0;
		if (bl_q != utv_pkg::BL_IDLE) begin
			// continuation: top two bits are not checked
			bl_n = bl_q - 2'd1;
			if (bl_n == utv_pkg::BL_IDLE) begin
				res_code = 1'b1;
				cp       = acc_cat;
				acc_n    = '0;
			end else begin
				acc_n = acc_cat;
			end
		end else if (!byte_in[7]) begin
			res_code = 1'b1;
			cp       = {{(utv_pkg::CP_W-utv_pkg::BYTE_W){1'b0}}, byte_in};
			acc_n    = '0;
		end else if (byte_in[7:6] == utv_pkg::CONT_TAG || byte_in[7:3] == utv_pkg::BAD_HIGH)
		begin
			res_bad = 1'b1;
			acc_n   = '0;
			bl_n    = utv_pkg::BL_IDLE;
		end else if (!byte_in[5]) begin
			acc_n = {{(utv_pkg::CP_W-5){1'b0}}, byte_in[4:0]};
			bl_n  = utv_pkg::BL_ONE;
		end else if (!byte_in[4]) begin
			acc_n = {{(utv_pkg::CP_W-4){1'b0}}, byte_in[3:0]};
			bl_n  = utv_pkg::BL_TWO;
		end else begin
			acc_n = {{(utv_pkg::CP_W-3){1'b0}}, byte_in[2:0]};
			bl_n  = utv_pkg::BL_THREE;
		end
	end

	assign first_more    = (cp[utv_pkg::CP_W-1:utv_pkg::GROUP_W] != '0);
	assign sts.res_valid = res_code || res_bad;
	assign sts.res_more  = res_code && first_more;
	assign sts.emit_last = (rest_q[utv_pkg::REST_W-1:utv_pkg::GROUP_W] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bl_q  <= utv_pkg::BL_IDLE;
			acc_q <= '0;
		end else if (cmd.take_in) begin
			bl_q  <= bl_n;
			acc_q <= acc_n;
		end
	end

	// payload registers: varint word out and the groups still to send
	always_ff @(posedge clk) begin
		if (cmd.take_in && res_code) begin
			obyte_q <= {first_more, cp[utv_pkg::GROUP_W-1:0]};
			olast_q <= !first_more;
			obad_q  <= 1'b0;
			rest_q  <= cp[utv_pkg::CP_W-1:utv_pkg::GROUP_W];
		end else if (cmd.take_in && res_bad) begin
			obyte_q <= '0;
			olast_q <= 1'b0;
			obad_q  <= 1'b1;
		end else if (cmd.emit_step) begin
			obyte_q <= {!sts.emit_last, rest_q[utv_pkg::GROUP_W-1:0]};
			olast_q <= sts.emit_last;
			obad_q  <= 1'b0;
			rest_q  <= {{utv_pkg::GROUP_W{1'b0}},
				rest_q[utv_pkg::REST_W-1:utv_pkg::GROUP_W]};
		end
	end

	assign byte_out  = obyte_q;
	assign last_byte = olast_q;
	assign bad_lead  = obad_q;

endmodule

// ===== hdl/utv_core.sv =====
// Top level of the UTF-8 to varint transcoder; joins controller and datapath.
// Depends on utv_pkg, utv_in_if, utv_out_if, utv_ctrl, utv_dp.

// ===== hdl/utf8_to_varint_transcoder_core.sv =====
// UTF-8 to LEB128 varint transcoder. Takes one UTF-8 byte per input word and,
// when a sequence completes, sends its code point as a little-endian base-128
// varint of one to three words, bit 7 set on all but the last, which carries
// last_byte. A continuation byte or 0xF8..0xFF in lead position gives one word
// with bad_lead set and byte_out zero, and decoding restarts. Overlong forms and
// surrogates pass through unchecked. While the varint of a code point is still
// being sent, the input is held and the emission sequencer shifts out the
// remaining 7-bit groups through the single output register, so the output
// port sets the pace: one word per cycle while the output is ready.
module utf8_to_varint_transcoder_core (
	input  logic      clk,
	input  logic      arst_n,
	utv_in_if.sink    din,
	utv_out_if.source dout
);

	utv_pkg::ctl_cmd_t cmd;
	utv_pkg::dp_sts_t  sts;

	utv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.out_ready (dout.ready),
		.out_valid (dout.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	utv_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (din.byte_in),
		.cmd       (cmd),
		.sts       (sts),
		.byte_out  (dout.byte_out),
		.last_byte (dout.last_byte),
		.bad_lead  (dout.bad_lead)
	);

`ifndef SYNTHESIS
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.take_in && cmd.emit_step))
		else $error("input taken during varint emission");

	a_bad_word: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.bad_lead |-> !dout.last_byte && dout.byte_out == '0)
		else $error("bad lead word carries payload");

	a_cont_bit: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.bad_lead |-> dout.byte_out[7] != dout.last_byte)
		else $error("continuation bit disagrees with last_byte");

	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_step |=> dout.valid)
		else $error("emission step left no word");
`endif

endmodule

// ===== sim/tb_utf8_to_varint_transcoder_core.sv =====
// Self-checking testbench for utf8_to_varint_transcoder_core: UTF-8 bytes in,
// varint words checked against an in-bench predictor, under varied idling.
// Depends on utv_pkg, utv_in_if, utv_out_if and the core itself.
`timescale 1ns / 100ps

module tb_utf8_to_varint_transcoder_core;

	localparam logic [7:0] CONT_BASE  = 8'h80;
	localparam logic [7:0] LEAD2_BASE = 8'hC0;
	localparam logic [7:0] LEAD3_BASE = 8'hE0;
	localparam logic [7:0] LEAD4_BASE = 8'hF0;
	localparam logic [7:0] BAD_FROM   = 8'hF8;
	localparam int         SETTLE_CYCLES = 20;
	localparam int         MAX_PRINTS    = 40;

	typedef struct packed {
		logic [utv_pkg::BYTE_W-1:0] byte_val;
		logic                       last;
		logic                       bad;
	} varint_word_t;

	logic clk = 1'b0;
	logic arst_n;

	utv_in_if  din_if ();
	utv_out_if dout_if ();

	utf8_to_varint_transcoder_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	always #5 clk = ~clk;

	logic [7:0]   pending_bytes[$];
	varint_word_t expected_words[$];
	varint_word_t want_word;
	int           src_idle_pct;
	int           snk_stall_pct;
	int           mismatch_count = 0;

	// predictor state: continuation bytes still owed and the code point so far
	logic [1:0]                 cont_left = utv_pkg::BL_IDLE;
	logic [utv_pkg::CP_W-1:0]   cp_acc = '0;

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTS)
			$display("%0t ns: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic push_varint(input logic [utv_pkg::CP_W-1:0] cp);
		logic [utv_pkg::CP_W-1:0] rest;
		logic                     done;
		varint_word_t             w;
		rest = cp;
		done = 1'b0;
		for (int n = 0; n < 3 && !done; n++) begin
			w.bad = 1'b0;
			// third group always closes the varint, whatever is left above it
			if ((rest >> utv_pkg::GROUP_W) == '0 || n == 2) begin
				w.byte_val = {1'b0, rest[6:0]};
				w.last = 1'b1;
				done = 1'b1;
			end else begin
				w.byte_val = {1'b1, rest[6:0]};
				w.last = 1'b0;
			end
			expected_words.push_back(w);
			rest = rest >> utv_pkg::GROUP_W;
		end
	endtask

	task automatic predict_varint_words(input logic [7:0] b);
		varint_word_t w;
		if (cont_left != utv_pkg::BL_IDLE) begin
			// top two bits of a continuation byte are ignored
			cp_acc = {cp_acc[utv_pkg::CP_W-7:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == utv_pkg::BL_IDLE) begin
				push_varint(cp_acc);
				cp_acc = '0;
			end
		end else if (b < CONT_BASE) begin
			cp_acc = '0;
			push_varint({{(utv_pkg::CP_W-8){1'b0}}, b});
		end else if (b < LEAD2_BASE || b >= BAD_FROM) begin
			cp_acc = '0;
			w.byte_val = '0;
			w.last = 1'b0;
			w.bad = 1'b1;
			expected_words.push_back(w);
		end else if (b < LEAD3_BASE) begin
			cp_acc = {{(utv_pkg::CP_W-5){1'b0}}, b[4:0]};
			cont_left = utv_pkg::BL_ONE;
		end else if (b < LEAD4_BASE) begin
			cp_acc = {{(utv_pkg::CP_W-4){1'b0}}, b[3:0]};
			cont_left = utv_pkg::BL_TWO;
		end else begin
			cp_acc = {{(utv_pkg::CP_W-3){1'b0}}, b[2:0]};
			cont_left = utv_pkg::BL_THREE;
		end
	endtask

	// queues n bytes of seq, most significant byte first
	task automatic push_bytes(input logic [31:0] seq, input int n);
		for (int i = n - 1; i >= 0; i--)
			pending_bytes.push_back(seq[i*8 +: 8]);
	endtask

	function automatic logic [7:0] cont_byte();
		// one in eight continuation bytes is drawn from the full byte range
		if ($urandom_range(7) == 0)
			return 8'($urandom_range(255));
		return CONT_BASE | 8'($urandom_range(63));
	endfunction

	task automatic gen_random(input int n_items);
		int   added;
		int   sel;
		int   seq_len;
		logic [7:0] lead;
		added = 0;
		while (added < n_items) begin
			sel = $urandom_range(99);
			if (sel < 30) begin
				seq_len = 1;
				lead = 8'($urandom_range(127));
			end else if (sel < 55) begin
				seq_len = 2;
				lead = LEAD2_BASE | 8'($urandom_range(31));
			end else if (sel < 78) begin
				seq_len = 3;
				lead = LEAD3_BASE | 8'($urandom_range(15));
			end else if (sel < 92) begin
				seq_len = 4;
				lead = LEAD4_BASE | 8'($urandom_range(7));
			end else begin
				seq_len = 1;
				lead = 8'($urandom_range(255));
			end
			pending_bytes.push_back(lead);
			for (int i = 1; i < seq_len; i++)
				pending_bytes.push_back(cont_byte());
			added += seq_len;
		end
	endtask

	// wait until every queued byte is sent and every expected word has been seen
	task automatic drain();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || din_if.valid);
		while (expected_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din_if.valid <= 1'b0;
			din_if.byte_in <= '0;
		end else begin
			if (din_if.valid && din_if.ready)
				predict_varint_words(din_if.byte_in);
			if (!din_if.valid || din_if.ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					din_if.valid <= 1'b1;
					din_if.byte_in <= pending_bytes.pop_front();
				end else begin
					din_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout_if.ready <= 1'b0;
		end else begin
			if (dout_if.valid && dout_if.ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("word %h with none expected", dout_if.byte_out));
				end else begin
					want_word = expected_words.pop_front();
					if (dout_if.byte_out !== want_word.byte_val)
						report_mismatch($sformatf("byte_out %h, expected %h",
							dout_if.byte_out, want_word.byte_val));
					if (dout_if.last_byte !== want_word.last)
						report_mismatch($sformatf("last_byte %b, expected %b",
							dout_if.last_byte, want_word.last));
					if (dout_if.bad_lead !== want_word.bad)
						report_mismatch($sformatf("bad_lead %b, expected %b",
							dout_if.bad_lead, want_word.bad));
				end
			end
			dout_if.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	initial begin
		#1_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;

		// ASCII extremes
		push_bytes(32'h00, 1);
		push_bytes(32'h7F, 1);
		// overlong zero, then max two-byte payload with malformed continuation
		push_bytes(32'hC080, 2);
		push_bytes(32'hDFFF, 2);
		// overlong three-byte, a surrogate, top of the BMP
		push_bytes(32'hE08080, 3);
		push_bytes(32'hED_A080, 3);
		push_bytes(32'hEFBFBF, 3);
		// first supplementary code point and the full 21-bit value
		push_bytes(32'hF0908080, 4);
		push_bytes(32'hF7FFFFFF, 4);
		// stray continuation bytes and bytes never valid as a lead
		push_bytes(32'h80BF, 2);
		push_bytes(32'hF8FF, 2);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		gen_random(45);
		drain();

		src_idle_pct = 81;
		gen_random(45);
		drain();

		src_idle_pct = 0;
		snk_stall_pct = 81;
		gen_random(45);
		drain();

		src_idle_pct = 36;
		snk_stall_pct = 36;
		gen_random(45);
		drain();

		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
